@@ hdl/hht3_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hht3_pkg
// Shared defaults and status codes of the 3x3 Householder tridiagonalizer.
// ----------------------------------------------------------------------------
package hht3_pkg;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_PASS = 2'd1,
        STATUS_SAT  = 2'd2
    } status_t;

endpackage
`default_nettype wire

@@ hdl/householder_tridiag_3x3_top.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// householder_tridiag_3x3_top
// Reduces a symmetric 3x3 matrix in signed fixed point to tridiagonal form
// with one Householder reflection.
//
// The s_ channel takes one word per matrix: the six distinct entries m00,
// m10, m20, m11, m21, m22. The m_ channel gives one word per matrix: diag0..2,
// sub0, sub1 and a status code (reflected, passed through because the column
// below the diagonal is zero, or saturated somewhere).
// Both channels use valid/ready. A new matrix is taken every cycle while
// the skid buffer is empty. The pipeline depth is set by the square root,
// one root bit a stage, and the two dividers, one quotient bit a stage each.
// When the receiver stalls, an output register and a one-word skid buffer
// absorb the word in flight; the pipeline then freezes and s_ready drops
// until the skid word moves out. Nothing is dropped or repeated.
// Synchronous active-low reset empties the pipeline and both output words.
// ----------------------------------------------------------------------------
module householder_tridiag_3x3_top #(
    parameter int DATA_WIDTH = hht3_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = hht3_pkg::FRAC_BITS_DEF
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [DATA_WIDTH-1:0] s_m00,
    input  wire logic signed [DATA_WIDTH-1:0] s_m10,
    input  wire logic signed [DATA_WIDTH-1:0] s_m20,
    input  wire logic signed [DATA_WIDTH-1:0] s_m11,
    input  wire logic signed [DATA_WIDTH-1:0] s_m21,
    input  wire logic signed [DATA_WIDTH-1:0] s_m22,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic signed [DATA_WIDTH-1:0]      m_diag0,
    output logic signed [DATA_WIDTH-1:0]      m_diag1,
    output logic signed [DATA_WIDTH-1:0]      m_diag2,
    output logic signed [DATA_WIDTH-1:0]      m_sub0,
    output logic signed [DATA_WIDTH-1:0]      m_sub1,
    output logic [1:0]                        m_status
);
    import hht3_pkg::*;

    localparam int W = DATA_WIDTH;

    typedef struct packed {
        logic [W-1:0] diag0;
        logic [W-1:0] diag1;
        logic [W-1:0] diag2;
        logic [W-1:0] sub0;
        logic [W-1:0] sub1;
        logic [1:0]   status;
    } res_t;

    logic  en;
    logic  core_valid;
    logic  emit;
    res_t  core_res;
    res_t  out_reg;
    res_t  skid_reg;
    logic  out_valid_reg;
    logic  skid_valid_reg;
    logic  load_out;

    assign en = ~skid_valid_reg;

    hht3_core #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .en         (en),
        .in_valid   (s_valid),
        .in_m00     (s_m00),
        .in_m10     (s_m10),
        .in_m20     (s_m20),
        .in_m11     (s_m11),
        .in_m21     (s_m21),
        .in_m22     (s_m22),
        .out_valid  (core_valid),
        .out_diag0  (core_res.diag0),
        .out_diag1  (core_res.diag1),
        .out_diag2  (core_res.diag2),
        .out_sub0   (core_res.sub0),
        .out_sub1   (core_res.sub1),
        .out_status (core_res.status)
    );

    assign emit     = en & core_valid;
    assign load_out = ~out_valid_reg | m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg  <= skid_valid_reg | emit;
            skid_valid_reg <= 1'b0;
        end else if (emit) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_reg <= skid_valid_reg ? skid_reg : core_res;
        end else if (emit) begin
            skid_reg <= core_res;
        end
    end

    assign s_ready  = en;
    assign m_valid  = out_valid_reg;
    assign m_diag0  = out_reg.diag0;
    assign m_diag1  = out_reg.diag1;
    assign m_diag2  = out_reg.diag2;
    assign m_sub0   = out_reg.sub0;
    assign m_sub1   = out_reg.sub1;
    assign m_status = out_reg.status;

endmodule
`default_nettype wire

@@ hdl/hht3_div.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hht3_div
// Pipelined restoring divider, one quotient bit per stage, with lanes that
// share one divisor. Gives round(num * 2^(FRAC_BITS+EXTRA) / den), half away
// from zero, saturated, and carries a side word along with each item.
// ----------------------------------------------------------------------------
module hht3_div #(
    parameter int DATA_WIDTH = hht3_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = hht3_pkg::FRAC_BITS_DEF,
    parameter int EXTRA      = 0,
    parameter int LANES      = 1,
    parameter int PW         = 1
) (
    input  wire logic                                 aclk,
    input  wire logic                                 aresetn,
    input  wire logic                                 en,
    input  wire logic                                 in_valid,
    input  wire logic [PW-1:0]                        in_ctx,
    input  wire logic [LANES-1:0][DATA_WIDTH-1:0]     in_num,
    input  wire logic [DATA_WIDTH-1:0]                in_den,
    output logic                                      out_valid,
    output logic [PW-1:0]                             out_ctx,
    output logic [LANES-1:0][DATA_WIDTH-1:0]          out_quo,
    output logic                                      out_sat
);
    import hht3_pkg::*;

    localparam int W  = DATA_WIDTH;
    localparam int SH = FRAC_BITS + EXTRA;
    localparam int NW = W + SH;
    localparam logic [W-1:0] LIM_HI = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0] LIM_LO = {1'b1, {(W-1){1'b0}}};
    localparam logic [W:0]   LIMU   = {2'b00, {(W-1){1'b1}}};
    localparam logic [W:0]   LIMU1  = {2'b01, {(W-1){1'b0}}};

    typedef struct packed {
        logic [PW-1:0]               ctx;
        logic [W-1:0]                den;
        logic                        dz;
        logic [LANES-1:0]            neg;
        logic [LANES-1:0]            ovf;
        logic [LANES-1:0]            nz;
        logic [LANES-1:0][W:0]       rem;
        logic [LANES-1:0][W-1:0]     lo;
        logic [LANES-1:0][W-1:0]     quo;
    } dstage_t;

    dstage_t                 ds_reg  [W+1];
    dstage_t                 ds_next [W+1];
    logic [W:0]              dv_reg;
    logic                    out_valid_reg;
    logic [PW-1:0]           out_ctx_reg;
    logic [LANES-1:0][W-1:0] out_quo_reg;
    logic                    out_sat_reg;
    logic [LANES-1:0][W-1:0] quo_next;
    logic                    sat_next;

    function automatic logic [W-1:0] mag(input logic [W-1:0] a);
        return a[W-1] ? (~a + 1'b1) : a;
    endfunction

    always_comb begin
        dstage_t       d;
        logic [NW-1:0] num_w;
        logic [W:0]    r2;
        logic          rnd;
        logic [W:0]    q;
        d = '0;
        d.ctx = in_ctx;
        d.den = in_den;
        d.dz  = (in_den == '0) | in_den[W-1];
        for (int l = 0; l < LANES; l++) begin
            num_w     = {mag(in_num[l]), {SH{1'b0}}};
            d.neg[l]  = in_num[l][W-1];
            d.nz[l]   = (in_num[l] != '0);
            // A high part at or above the divisor means a quotient of 2^W or more.
            d.ovf[l]  = (num_w >> W) >= NW'(in_den);
            d.rem[l]  = (W+1)'(num_w >> W);
            d.lo[l]   = num_w[W-1:0];
        end
        ds_next[0] = d;

        for (int i = 1; i <= W; i++) begin
            d = ds_reg[i-1];
            for (int l = 0; l < LANES; l++) begin
                r2       = {d.rem[l][W-1:0], d.lo[l][W-1]};
                d.lo[l]  = d.lo[l] << 1;
                if (r2 >= {1'b0, d.den}) begin
                    d.rem[l] = r2 - {1'b0, d.den};
                    d.quo[l] = {d.quo[l][W-2:0], 1'b1};
                end else begin
                    d.rem[l] = r2;
                    d.quo[l] = {d.quo[l][W-2:0], 1'b0};
                end
            end
            ds_next[i] = d;
        end

        d = ds_reg[W];
        sat_next = 1'b0;
        for (int l = 0; l < LANES; l++) begin
            rnd = {d.rem[l], 1'b0} >= {2'b00, d.den};
            q   = {1'b0, d.quo[l]} + (W+1)'(rnd);
            if (d.dz) begin
                sat_next    = 1'b1;
                quo_next[l] = d.nz[l] ? (d.neg[l] ? LIM_LO : LIM_HI) : '0;
            end else if (d.ovf[l]) begin
                sat_next    = 1'b1;
                quo_next[l] = d.neg[l] ? LIM_LO : LIM_HI;
            end else if (!d.neg[l]) begin
                if (q > LIMU) begin
                    sat_next    = 1'b1;
                    quo_next[l] = LIM_HI;
                end else begin
                    quo_next[l] = q[W-1:0];
                end
            end else begin
                if (q > LIMU1) begin
                    sat_next    = 1'b1;
                    quo_next[l] = LIM_LO;
                end else begin
                    quo_next[l] = ~q[W-1:0] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dv_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            dv_reg        <= {dv_reg[W-1:0], in_valid};
            out_valid_reg <= dv_reg[W];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i <= W; i++) begin
                ds_reg[i] <= ds_next[i];
            end
            out_ctx_reg <= ds_reg[W].ctx;
            out_quo_reg <= quo_next;
            out_sat_reg <= sat_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_ctx   = out_ctx_reg;
    assign out_quo   = out_quo_reg;
    assign out_sat   = out_sat_reg;

endmodule
`default_nettype wire

@@ hdl/hht3_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hht3_core
// Datapath pipeline of the Householder step: norm by a bit-per-stage square
// root, reflector, B*v, two pipelined dividers and the rank-2 update.
// ----------------------------------------------------------------------------
module hht3_core #(
    parameter int DATA_WIDTH = hht3_pkg::DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = hht3_pkg::FRAC_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  en,
    input  wire logic                  in_valid,
    input  wire logic [DATA_WIDTH-1:0] in_m00,
    input  wire logic [DATA_WIDTH-1:0] in_m10,
    input  wire logic [DATA_WIDTH-1:0] in_m20,
    input  wire logic [DATA_WIDTH-1:0] in_m11,
    input  wire logic [DATA_WIDTH-1:0] in_m21,
    input  wire logic [DATA_WIDTH-1:0] in_m22,
    output logic                       out_valid,
    output logic [DATA_WIDTH-1:0]      out_diag0,
    output logic [DATA_WIDTH-1:0]      out_diag1,
    output logic [DATA_WIDTH-1:0]      out_diag2,
    output logic [DATA_WIDTH-1:0]      out_sub0,
    output logic [DATA_WIDTH-1:0]      out_sub1,
    output logic [1:0]                 out_status
);
    import hht3_pkg::*;

    localparam int W   = DATA_WIDTH;
    localparam int FW  = 2 * W + 2;
    localparam int NSQ = W + 1;
    localparam logic [W-1:0]  LIM_HI = {1'b0, {(W-1){1'b1}}};
    localparam logic [W-1:0]  LIM_LO = {1'b1, {(W-1){1'b0}}};
    localparam logic [FW-1:0] LIMU   = {{(FW-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [FW-1:0] LIMU1  = LIMU + FW'(1);

    // Stage numbering.
    localparam int S_IN  = 0;
    localparam int S_SQ  = 1;
    localparam int S_N   = 2;
    localparam int S_RT0 = 3;
    localparam int S_NRM = S_RT0 + NSQ;
    localparam int S_V   = S_NRM + 1;
    localparam int S_P1  = S_V + 1;
    localparam int S_P2  = S_P1 + 1;
    localparam int S_P3  = S_P2 + 1;
    localparam int S_Q1  = S_P3 + 1;
    localparam int S_Q2  = S_Q1 + 1;
    localparam int S_Q3  = S_Q2 + 1;
    localparam int S_K1  = S_Q3 + 1;
    localparam int S_K2  = S_K1 + 1;
    localparam int S_K3  = S_K2 + 1;
    localparam int S_T1  = S_K3 + 1;
    localparam int S_T2  = S_T1 + 1;
    localparam int S_T3  = S_T2 + 1;
    localparam int S_T4  = S_T3 + 1;
    localparam int NS    = S_T4 + 1;

    typedef struct packed {
        logic                  xz;
        logic                  sat;
        logic [W-1:0]          a00;
        logic [W-1:0]          x0;
        logic [W-1:0]          x1;
        logic [W-1:0]          b00;
        logic [W-1:0]          b10;
        logic [W-1:0]          b11;
        logic [2*W:0]          n;
        logic [W:0]            root;
        logic [FW-1:0]         rem;
        logic [W-1:0]          alpha;
        logic [W-1:0]          v0;
        logic [W-1:0]          v1;
        logic [W-1:0]          vv;
        logic [W-1:0]          p0;
        logic [W-1:0]          p1;
        logic [W-1:0]          w0;
        logic [W-1:0]          w1;
        logic [W-1:0]          kv;
        logic [W-1:0]          q0;
        logic [W-1:0]          q1;
        logic [W-1:0]          d1;
        logic [W-1:0]          d2;
        logic [W-1:0]          s1;
        logic [5:0]            ng;
        logic [5:0][2*W-1:0]   pm;
        logic [5:0][W-1:0]     r;
    } ctx_t;

    localparam int CTX_W = $bits(ctx_t);

    ctx_t            stg_reg  [NS];
    ctx_t            stg_next [NS];
    logic [NS-1:0]   vld_reg;
    logic [NS-1:0]   vld_src;

    logic                  diva_vld;
    logic [CTX_W-1:0]      diva_ctx;
    logic [1:0][W-1:0]     diva_quo;
    logic                  diva_sat;
    logic                  divb_vld;
    logic [CTX_W-1:0]      divb_ctx;
    logic [0:0][W-1:0]     divb_quo;
    logic                  divb_sat;
    logic [1:0][W-1:0]     diva_num;
    logic [0:0][W-1:0]     divb_num;
    ctx_t                  last;

    function automatic logic [W-1:0] mag(input logic [W-1:0] a);
        return a[W-1] ? (~a + 1'b1) : a;
    endfunction

    function automatic logic [2*W:0] prod(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [2*W-1:0] ma;
        logic [2*W-1:0] mb;
        ma = (2*W)'(mag(a));
        mb = (2*W)'(mag(b));
        return {a[W-1] ^ b[W-1], ma * mb};
    endfunction

    // Result word carries the saturation flag in its top bit.
    function automatic logic [W:0] fit(input logic neg, input logic [FW-1:0] m);
        logic [W:0] res;
        if (!neg) begin
            res = (m > LIMU) ? {1'b1, LIM_HI} : {1'b0, m[W-1:0]};
        end else if (m > LIMU1) begin
            res = {1'b1, LIM_LO};
        end else begin
            res = {1'b0, ~m[W-1:0] + 1'b1};
        end
        return res;
    endfunction

    function automatic logic [W:0] mul_fin(input logic neg, input logic [2*W-1:0] pm);
        logic [FW-1:0] m;
        m = (FW'(pm) + (FW'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
        return fit(neg, m);
    endfunction

    function automatic logic [W:0] add_s(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} + {b[W-1], b};
        if (s[W] != s[W-1]) begin
            return {1'b1, s[W] ? LIM_LO : LIM_HI};
        end
        return {1'b0, s[W-1:0]};
    endfunction

    function automatic logic [W:0] sub_s(input logic [W-1:0] a, input logic [W-1:0] b);
        logic [W:0] s;
        s = {a[W-1], a} - {b[W-1], b};
        if (s[W] != s[W-1]) begin
            return {1'b1, s[W] ? LIM_LO : LIM_HI};
        end
        return {1'b0, s[W-1:0]};
    endfunction

    always_comb begin
        ctx_t          c;
        logic [W:0]    f;
        logic [2*W:0]  p;
        logic [FW-1:0] t;
        logic [FW-1:0] rr;
        logic [W-1:0]  nrm;

        vld_src        = {vld_reg[NS-2:0], in_valid};
        vld_src[S_Q1]  = diva_vld;
        vld_src[S_K1]  = divb_vld;

        for (int i = 1; i < NS; i++) begin
            stg_next[i] = stg_reg[i-1];
        end
        stg_next[S_Q1] = ctx_t'(diva_ctx);
        stg_next[S_K1] = ctx_t'(divb_ctx);

        c     = '0;
        c.a00 = in_m00;
        c.x0  = in_m10;
        c.x1  = in_m20;
        c.b00 = in_m11;
        c.b10 = in_m21;
        c.b11 = in_m22;
        c.xz  = (in_m10 == '0) && (in_m20 == '0);
        stg_next[S_IN] = c;

        c = stg_next[S_SQ];
        p = prod(c.x0, c.x0);
        c.pm[0] = p[2*W-1:0];
        p = prod(c.x1, c.x1);
        c.pm[1] = p[2*W-1:0];
        stg_next[S_SQ] = c;

        c = stg_next[S_N];
        c.n    = {1'b0, c.pm[0]} + {1'b0, c.pm[1]};
        c.rem  = FW'(c.n);
        c.root = '0;
        stg_next[S_N] = c;

        // One root bit per stage; rem tracks n - root^2.
        for (int i = 0; i < NSQ; i++) begin
            c = stg_next[S_RT0 + i];
            t = (FW'(c.root) << (W - i + 1)) + (FW'(1) << (2 * (W - i)));
            if (c.rem >= t) begin
                c.rem         = c.rem - t;
                c.root[W - i] = 1'b1;
            end
            stg_next[S_RT0 + i] = c;
        end

        c  = stg_next[S_NRM];
        rr = FW'(c.root);
        if ((c.rem > rr) && (rr >= LIMU)) begin
            c.sat = 1'b1;
            nrm   = LIM_HI;
        end else begin
            f     = fit(1'b0, rr + FW'(c.rem > rr));
            c.sat = c.sat | f[W];
            nrm   = f[W-1:0];
        end
        c.alpha = c.x0[W-1] ? nrm : (~nrm + 1'b1);
        stg_next[S_NRM] = c;

        c = stg_next[S_V];
        f = sub_s(c.x0, c.alpha);
        c.v0  = f[W-1:0];
        c.sat = c.sat | f[W];
        c.v1  = c.x1;
        stg_next[S_V] = c;

        c = stg_next[S_P1];
        p = prod(c.v0, c.v0);   c.ng[0] = p[2*W]; c.pm[0] = p[2*W-1:0];
        p = prod(c.v1, c.v1);   c.ng[1] = p[2*W]; c.pm[1] = p[2*W-1:0];
        p = prod(c.b00, c.v0);  c.ng[2] = p[2*W]; c.pm[2] = p[2*W-1:0];
        p = prod(c.b10, c.v1);  c.ng[3] = p[2*W]; c.pm[3] = p[2*W-1:0];
        p = prod(c.b10, c.v0);  c.ng[4] = p[2*W]; c.pm[4] = p[2*W-1:0];
        p = prod(c.b11, c.v1);  c.ng[5] = p[2*W]; c.pm[5] = p[2*W-1:0];
        stg_next[S_P1] = c;

        c = stg_next[S_P2];
        for (int j = 0; j < 6; j++) begin
            f = mul_fin(c.ng[j], c.pm[j]);
            c.r[j] = f[W-1:0];
            c.sat  = c.sat | f[W];
        end
        stg_next[S_P2] = c;

        c = stg_next[S_P3];
        f = add_s(c.r[0], c.r[1]); c.vv = f[W-1:0]; c.sat = c.sat | f[W];
        f = add_s(c.r[2], c.r[3]); c.p0 = f[W-1:0]; c.sat = c.sat | f[W];
        f = add_s(c.r[4], c.r[5]); c.p1 = f[W-1:0]; c.sat = c.sat | f[W];
        stg_next[S_P3] = c;

        c = stg_next[S_Q1];
        c.w0  = diva_quo[0];
        c.w1  = diva_quo[1];
        c.sat = c.sat | diva_sat;
        p = prod(c.v0, c.w0);   c.ng[0] = p[2*W]; c.pm[0] = p[2*W-1:0];
        p = prod(c.v1, c.w1);   c.ng[1] = p[2*W]; c.pm[1] = p[2*W-1:0];
        stg_next[S_Q1] = c;

        c = stg_next[S_Q2];
        for (int j = 0; j < 2; j++) begin
            f = mul_fin(c.ng[j], c.pm[j]);
            c.r[j] = f[W-1:0];
            c.sat  = c.sat | f[W];
        end
        stg_next[S_Q2] = c;

        c = stg_next[S_Q3];
        f = add_s(c.r[0], c.r[1]); c.kv = f[W-1:0]; c.sat = c.sat | f[W];
        stg_next[S_Q3] = c;

        c = stg_next[S_K1];
        c.kv  = divb_quo[0];
        c.sat = c.sat | divb_sat;
        p = prod(c.kv, c.v0);   c.ng[0] = p[2*W]; c.pm[0] = p[2*W-1:0];
        p = prod(c.kv, c.v1);   c.ng[1] = p[2*W]; c.pm[1] = p[2*W-1:0];
        stg_next[S_K1] = c;

        c = stg_next[S_K2];
        for (int j = 0; j < 2; j++) begin
            f = mul_fin(c.ng[j], c.pm[j]);
            c.r[j] = f[W-1:0];
            c.sat  = c.sat | f[W];
        end
        stg_next[S_K2] = c;

        c = stg_next[S_K3];
        f = sub_s(c.w0, c.r[0]); c.q0 = f[W-1:0]; c.sat = c.sat | f[W];
        f = sub_s(c.w1, c.r[1]); c.q1 = f[W-1:0]; c.sat = c.sat | f[W];
        stg_next[S_K3] = c;

        c = stg_next[S_T1];
        p = prod(c.v0, c.q0);   c.ng[0] = p[2*W]; c.pm[0] = p[2*W-1:0];
        p = prod(c.v1, c.q1);   c.ng[1] = p[2*W]; c.pm[1] = p[2*W-1:0];
        p = prod(c.v0, c.q1);   c.ng[2] = p[2*W]; c.pm[2] = p[2*W-1:0];
        p = prod(c.q0, c.v1);   c.ng[3] = p[2*W]; c.pm[3] = p[2*W-1:0];
        stg_next[S_T1] = c;

        c = stg_next[S_T2];
        for (int j = 0; j < 4; j++) begin
            f = mul_fin(c.ng[j], c.pm[j]);
            c.r[j] = f[W-1:0];
            c.sat  = c.sat | f[W];
        end
        stg_next[S_T2] = c;

        c = stg_next[S_T3];
        f = add_s(c.r[2], c.r[3]); c.r[2] = f[W-1:0]; c.sat = c.sat | f[W];
        f = add_s(c.r[0], c.r[0]); c.r[0] = f[W-1:0]; c.sat = c.sat | f[W];
        f = add_s(c.r[1], c.r[1]); c.r[1] = f[W-1:0]; c.sat = c.sat | f[W];
        stg_next[S_T3] = c;

        c = stg_next[S_T4];
        f = sub_s(c.b00, c.r[0]); c.d1 = f[W-1:0]; c.sat = c.sat | f[W];
        f = sub_s(c.b11, c.r[1]); c.d2 = f[W-1:0]; c.sat = c.sat | f[W];
        f = sub_s(c.b10, c.r[2]); c.s1 = f[W-1:0]; c.sat = c.sat | f[W];
        stg_next[S_T4] = c;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_src;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int i = 0; i < NS; i++) begin
                stg_reg[i] <= stg_next[i];
            end
        end
    end

    assign diva_num[0] = stg_reg[S_P3].p0;
    assign diva_num[1] = stg_reg[S_P3].p1;
    assign divb_num[0] = stg_reg[S_Q3].kv;

    // w = 2 p / vv carries one extra fraction bit of scale.
    hht3_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .EXTRA      (1),
        .LANES      (2),
        .PW         (CTX_W)
    ) u_div_w (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld_reg[S_P3]),
        .in_ctx    (stg_reg[S_P3]),
        .in_num    (diva_num),
        .in_den    (stg_reg[S_P3].vv),
        .out_valid (diva_vld),
        .out_ctx   (diva_ctx),
        .out_quo   (diva_quo),
        .out_sat   (diva_sat)
    );

    hht3_div #(
        .DATA_WIDTH (DATA_WIDTH),
        .FRAC_BITS  (FRAC_BITS),
        .EXTRA      (0),
        .LANES      (1),
        .PW         (CTX_W)
    ) u_div_k (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (vld_reg[S_Q3]),
        .in_ctx    (stg_reg[S_Q3]),
        .in_num    (divb_num),
        .in_den    (stg_reg[S_Q3].vv),
        .out_valid (divb_vld),
        .out_ctx   (divb_ctx),
        .out_quo   (divb_quo),
        .out_sat   (divb_sat)
    );

    assign last      = stg_reg[S_T4];
    assign out_valid = vld_reg[NS-1];
    assign out_diag0 = last.a00;
    assign out_diag1 = last.xz ? last.b00 : last.d1;
    assign out_diag2 = last.xz ? last.b11 : last.d2;
    assign out_sub0  = last.xz ? '0 : last.alpha;
    assign out_sub1  = last.xz ? last.b10 : last.s1;

    always_comb begin
        status_t st;
        if (last.xz) begin
            st = STATUS_PASS;
        end else if (last.sat) begin
            st = STATUS_SAT;
        end else begin
            st = STATUS_OK;
        end
        out_status = st;
    end

endmodule
`default_nettype wire

@@ hdl/hht3_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hht3_checker
// Port-level checks on the tridiagonalizer, attached to the top by bind.
// ----------------------------------------------------------------------------
module hht3_checker #(
    parameter int DATA_WIDTH = hht3_pkg::DATA_WIDTH_DEF
) (
    input wire logic                  aclk,
    input wire logic                  aresetn,
    input wire logic                  s_ready,
    input wire logic                  m_valid,
    input wire logic                  m_ready,
    input wire logic [DATA_WIDTH-1:0] m_diag1,
    input wire logic [DATA_WIDTH-1:0] m_sub0,
    input wire logic [1:0]            m_status
);
    import hht3_pkg::*;

    // Reset empties the output word.
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("output word valid after reset");

    // A stalled output word stays valid with diag1 and status unchanged.
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_diag1) && $stable(m_status))
        else $error("stalled output word changed");

    // The input side backs up only when the output register is occupied.
    a_ready_backpressure: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> m_valid)
        else $error("input stalled with empty output register");

    // A passed-through matrix has a zero first subdiagonal.
    a_pass_sub0: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == STATUS_PASS |-> m_sub0 == '0)
        else $error("pass-through word with nonzero sub0");

endmodule

bind householder_tridiag_3x3_top hht3_checker #(
    .DATA_WIDTH (DATA_WIDTH)
) u_hht3_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_diag1  (m_diag1),
    .m_sub0   (m_sub0),
    .m_status (m_status)
);
`default_nettype wire

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the 3x3 Householder tridiagonalizer. Each accepted
// matrix is reduced by a bit-accurate fixed-point predictor and the result is
// queued; every output word is compared field by field with the oldest entry.
// Both channels idle at random, with a stretch of full-rate streaming.
// ----------------------------------------------------------------------------
module tb;
    import hht3_pkg::*;

    localparam int     DW        = DATA_WIDTH_DEF;
    localparam int     FB        = FRAC_BITS_DEF;
    localparam longint Q_MAX     = (longint'(1) <<< (DW - 1)) - 1;
    localparam longint Q_MIN     = -Q_MAX - 1;
    localparam longint Q_ONE     = longint'(1) <<< FB;
    localparam int     LATENCY   = 3 * DW + 23;
    localparam int     MAX_CYCLES = 400000;

    typedef logic signed [127:0] wide_t;

    typedef struct {
        logic signed [DW-1:0] diag0, diag1, diag2, sub0, sub1;
        status_t              status;
    } tridiag_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [DW-1:0] s_m00 = '0, s_m10 = '0, s_m20 = '0;
    logic signed [DW-1:0] s_m11 = '0, s_m21 = '0, s_m22 = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic signed [DW-1:0] m_diag0, m_diag1, m_diag2, m_sub0, m_sub1;
    logic [1:0] m_status;

    tridiag_t expected_q[$];
    int  mismatches = 0;
    int  cycles = 0;
    bit  no_idle = 1'b0;
    bit  sat_hit;

    householder_tridiag_3x3_top u_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_m00(s_m00), .s_m10(s_m10), .s_m20(s_m20),
        .s_m11(s_m11), .s_m21(s_m21), .s_m22(s_m22),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_diag0(m_diag0), .m_diag1(m_diag1), .m_diag2(m_diag2),
        .m_sub0(m_sub0), .m_sub1(m_sub1), .m_status(m_status)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // ---------------- fixed-point predictor ----------------
    function automatic wide_t magnitude(wide_t a);
        return (a < 0) ? -a : a;
    endfunction

    function automatic longint clamp_q(wide_t v);
        if (v > Q_MAX) begin
            sat_hit = 1'b1;
            return Q_MAX;
        end
        if (v < Q_MIN) begin
            sat_hit = 1'b1;
            return Q_MIN;
        end
        return longint'(v);
    endfunction

    function automatic longint q_add(longint a, longint b);
        return clamp_q(wide_t'(a) + wide_t'(b));
    endfunction

    function automatic longint q_sub(longint a, longint b);
        return clamp_q(wide_t'(a) - wide_t'(b));
    endfunction

    // Rounds half away from zero by working on magnitudes.
    function automatic longint q_mul(longint a, longint b);
        wide_t m;
        m = (magnitude(a) * magnitude(b) + (wide_t'(1) <<< (FB - 1))) >>> FB;
        if ((a < 0) != (b < 0)) m = -m;
        return clamp_q(m);
    endfunction

    function automatic longint q_div(longint n, longint d, int extra);
        wide_t num, quo, rem;
        if (d <= 0) begin
            sat_hit = 1'b1;
            return (n > 0) ? Q_MAX : ((n < 0) ? Q_MIN : 0);
        end
        num = magnitude(n) <<< (FB + extra);
        quo = num / d;
        rem = num - quo * d;
        if (rem >= d - rem) quo = quo + 1;
        if (n < 0) quo = -quo;
        return clamp_q(quo);
    endfunction

    function automatic longint q_norm(longint a, longint b);
        logic [127:0] sq, root, trial;
        sq = magnitude(a) * magnitude(a) + magnitude(b) * magnitude(b);
        root = '0;
        for (int k = 63; k >= 0; k--) begin
            trial = root | (128'd1 << k);
            if (trial * trial <= sq) root = trial;
        end
        if (sq > root * root + root) root = root + 1;
        return clamp_q(wide_t'(root));
    endfunction

    function automatic tridiag_t reduce_matrix(longint a00, longint x0, longint x1,
                                               longint b00, longint b10, longint b11);
        tridiag_t r;
        longint nrm, alpha, v0, v1, vv, p0, p1, w0, w1, kk, q0, q1, t0, t1;
        sat_hit = 1'b0;
        r.diag0 = DW'(a00);
        if (x0 == 0 && x1 == 0) begin
            r.diag1 = DW'(b00);
            r.diag2 = DW'(b11);
            r.sub0 = '0;
            r.sub1 = DW'(b10);
            r.status = STATUS_PASS;
            return r;
        end
        nrm = q_norm(x0, x1);
        alpha = (x0 >= 0) ? -nrm : nrm;
        v0 = q_sub(x0, alpha);
        v1 = x1;
        vv = q_add(q_mul(v0, v0), q_mul(v1, v1));
        p0 = q_add(q_mul(b00, v0), q_mul(b10, v1));
        p1 = q_add(q_mul(b10, v0), q_mul(b11, v1));
        w0 = q_div(p0, vv, 1);
        w1 = q_div(p1, vv, 1);
        kk = q_div(q_add(q_mul(v0, w0), q_mul(v1, w1)), vv, 0);
        q0 = q_sub(w0, q_mul(kk, v0));
        q1 = q_sub(w1, q_mul(kk, v1));
        t0 = q_mul(v0, q0);
        t1 = q_mul(v1, q1);
        r.diag1 = DW'(q_sub(b00, q_add(t0, t0)));
        r.diag2 = DW'(q_sub(b11, q_add(t1, t1)));
        r.sub1 = DW'(q_sub(b10, q_add(q_mul(v0, q1), q_mul(q0, v1))));
        r.sub0 = DW'(alpha);
        r.status = sat_hit ? STATUS_SAT : STATUS_OK;
        return r;
    endfunction

    // ---------------- monitor and checker ----------------
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > MAX_CYCLES) begin
            $display("householder_tridiag_3x3_top test failed");
            $finish;
        end
        if (aresetn && s_valid && s_ready)
            expected_q.push_back(reduce_matrix(s_m00, s_m10, s_m20, s_m11, s_m21, s_m22));
        if (aresetn && m_valid && m_ready) begin
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result word at %0t", $realtime);
            end else begin
                tridiag_t e;
                e = expected_q.pop_front();
                if (m_diag0 !== e.diag0 || m_diag1 !== e.diag1 || m_diag2 !== e.diag2 ||
                    m_sub0 !== e.sub0 || m_sub1 !== e.sub1 || m_status !== e.status) begin
                    mismatches++;
                    if (mismatches <= 10) begin
                        $display("mismatch at %0t: expected d=%0d %0d %0d s=%0d %0d st=%0d",
                                 $realtime, e.diag0, e.diag1, e.diag2, e.sub0, e.sub1,
                                 e.status);
                        $display("               got      d=%0d %0d %0d s=%0d %0d st=%0d",
                                 m_diag0, m_diag1, m_diag2, m_sub0, m_sub1, m_status);
                    end
                end
            end
        end
    end

    // The receiver stalls at random except during the no-idle stretch.
    always @(posedge aclk) begin
        m_ready <= no_idle || ($urandom_range(99) >= 8);
    end

    // ---------------- stimulus ----------------
    task automatic send_matrix(longint a00, longint x0, longint x1,
                               longint b00, longint b10, longint b11);
        s_valid <= 1'b1;
        s_m00 <= DW'(a00); s_m10 <= DW'(x0); s_m20 <= DW'(x1);
        s_m11 <= DW'(b00); s_m21 <= DW'(b10); s_m22 <= DW'(b11);
        do @(posedge aclk); while (!s_ready);
        // Short random gaps keep the sender idle about 8% of the time.
        if (!no_idle && $urandom_range(99) < 4) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (expected_q.size() != 0) @(posedge aclk);
    endtask

    function automatic longint rand_entry();
        case ($urandom_range(9))
            0:       return longint'($signed($urandom()));
            1:       return ($urandom_range(1)) ? Q_MAX : Q_MIN;
            2:       return 0;
            3:       return longint'($signed($urandom())) >>> $urandom_range(31);
            default: return longint'($urandom_range(0, 16 * Q_ONE)) - 8 * Q_ONE;
        endcase
    endfunction

    task automatic test_directed();
        send_matrix(Q_ONE, 0, 0, 2 * Q_ONE, -3 * Q_ONE, 4 * Q_ONE);  // zero column
        send_matrix(Q_MAX, 0, 0, Q_MIN, Q_MAX, Q_MIN);
        send_matrix(Q_ONE, 3 * Q_ONE, 4 * Q_ONE, Q_ONE, Q_ONE / 2, -Q_ONE);
        send_matrix(Q_ONE, -3 * Q_ONE, 4 * Q_ONE, Q_ONE, Q_ONE / 2, -Q_ONE);
        send_matrix(0, 0, 5 * Q_ONE, Q_ONE, 2 * Q_ONE, 3 * Q_ONE);  // x0 zero
        send_matrix(0, 0, -5 * Q_ONE, Q_ONE, 2 * Q_ONE, 3 * Q_ONE);
        send_matrix(0, 1, 0, Q_ONE, Q_ONE, Q_ONE);                  // degenerate vv
        send_matrix(0, -1, 1, Q_ONE, -Q_ONE, Q_ONE);
        send_matrix(0, 0, 1, Q_ONE, 0, 0);
        send_matrix(Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX, Q_MAX);     // saturation
        send_matrix(Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN, Q_MIN);
        send_matrix(Q_MIN, Q_MAX, Q_MIN, Q_MAX, Q_MIN, Q_MAX);
        send_matrix(-1, -1, -1, -1, -1, -1);
        send_matrix(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE);
        send_matrix(0, Q_ONE / 4, -Q_ONE / 4, 100 * Q_ONE, -7 * Q_ONE, 50 * Q_ONE);
    endtask

    task automatic test_pause_until_drained();
        wait_drain();
        repeat (10) @(posedge aclk);
        send_matrix(2 * Q_ONE, Q_ONE, -2 * Q_ONE, 3 * Q_ONE, Q_ONE, -Q_ONE);
    endtask

    task automatic test_random(int count);
        longint x0, x1;
        for (int i = 0; i < count; i++) begin
            x0 = rand_entry();
            x1 = rand_entry();
            if ($urandom_range(19) == 0) begin
                x0 = 0;
                x1 = 0;
            end
            send_matrix(rand_entry(), x0, x1, rand_entry(), rand_entry(), rand_entry());
        end
    endtask

    task automatic test_full_rate(int count);
        no_idle = 1'b1;
        test_random(count);
        no_idle = 1'b0;
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_directed();
        test_pause_until_drained();
        test_random(250);
        test_full_rate(150);
        test_random(100);
        wait_drain();
        repeat (LATENCY + 50) @(posedge aclk);
        if (mismatches == 0 && expected_q.size() == 0)
            $display("householder_tridiag_3x3_top test passed");
        else
            $display("householder_tridiag_3x3_top test failed");
        $finish;
    end
endmodule

@@ sim.f @@
hdl/hht3_pkg.sv
hdl/hht3_div.sv
hdl/hht3_core.sv
hdl/householder_tridiag_3x3_top.sv
hdl/hht3_checker.sv
tb/tb.sv
